### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/egd_pkg.sv
// Package for the ElGamal decryption block: widths, register indexes, states.
// No dependencies.
`timescale 1ns / 1ps

package egd_pkg;

    localparam int DATA_W              = 32;  // payload and APB data width
    localparam int VALUE_WIDTH_DEFAULT = 32;  // arithmetic width
    localparam int APB_ADDR_W          = 3;   // two registers at byte offsets 0 and 4

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_MODULUS      = 1'b0,
        REG_PRIV_EXP     = 1'b1
    } reg_idx_t;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_RED_R = 7'b000_0010,
        ST_SQ    = 7'b000_0100,
        ST_MUL   = 7'b000_1000,
        ST_RED_M = 7'b001_0000,
        ST_FINAL = 7'b010_0000,
        ST_OUT   = 7'b100_0000
    } egd_state_t;

endpackage

### rtl/egd_modmul.sv
// Bit-serial interleaved modular multiplier: result = (x * y) mod p.
// Needs x < p; y is any value. One bit of y per cycle. Uses egd_pkg.
`timescale 1ns / 1ps

module egd_modmul #(
    parameter int VALUE_WIDTH = egd_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] x,
    input  logic [VALUE_WIDTH-1:0] y,
    input  logic [VALUE_WIDTH-1:0] p,
    output logic                   busy,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);
    import egd_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;

    logic [W+1:0]  sum;
    logic [W+1:0]  p1;
    logic [W+1:0]  p2;
    logic [W-1:0]  acc_next;

    // acc < p, x < p, so 2*acc + x < 3p: at most one subtraction of p or 2p
    always_comb begin
        p1  = {2'b00, p};
        p2  = {1'b0, p, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + (y_reg[W-1] ? {2'b00, x_reg} : '0);
        if (sum >= p2) begin
            acc_next = W'(sum - p2);
        end else if (sum >= p1) begin
            acc_next = W'(sum - p1);
        end else begin
            acc_next = W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CW'(W - 1);
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            acc_reg <= acc_next;
            y_reg   <= y_reg << 1;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### rtl/elgamal_decrypt_mod_p.sv
// Throughput: one item at a time; the single bit-serial modular multiplier sets the pace.
// Reset (aresetn, synchronous, active low): modulus = 3, private exponent = 0, idle.
// Uses egd_pkg, egd_modmul and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module elgamal_decrypt_mod_p #(
    parameter int VALUE_WIDTH = egd_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB-style configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [egd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [egd_pkg::DATA_W-1:0]      pwdata,
    output logic [egd_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    // Ciphertext items in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [egd_pkg::DATA_W-1:0]      s_ephemeral_value,
    input  logic [egd_pkg::DATA_W-1:0]      s_masked_value,
    // Plaintext items out
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [egd_pkg::DATA_W-1:0]      m_plain_value
);
    import egd_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    // ---------------------------------------------------------------
    // Configuration registers; values kept to their low W bits
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] modulus_reg;
    logic [DATA_W-1:0] exponent_reg;
    reg_idx_t          reg_idx;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= DATA_W'(3);
            exponent_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_MODULUS:  modulus_reg  <= DATA_W'(pwdata[W-1:0]);
                REG_PRIV_EXP: exponent_reg <= DATA_W'(pwdata[W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODULUS:  prdata = modulus_reg;
            REG_PRIV_EXP: prdata = exponent_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    //   RED_R : r mod p          (as 1 * r on the multiplier)
    //   SQ/MUL: square-and-multiply, first k = r^a, then inv = k^(p-2)
    //   RED_M : m mod p
    //   FINAL : (m mod p) * inv
    // Each multiplier call is started in the cycle in which the
    // previous call signals done, so no wait state lies between calls.
    // ---------------------------------------------------------------
    egd_state_t    state_reg, state_next;
    logic [W-1:0]  acc_reg,  acc_next;    // exponentiation accumulator
    logic [W-1:0]  base_reg, base_next;   // exponentiation base, later m mod p
    logic [W-1:0]  exp_reg,  exp_next;    // exponent, msb first
    logic [CW-1:0] cnt_reg,  cnt_next;    // exponent bit count
    logic          pass_reg, pass_next;   // 0: shared key, 1: inverse
    logic [W-1:0]  mval_reg, mval_next;   // masked value as received
    logic [W-1:0]  out_reg,  out_next;    // result holding register

    logic [W-1:0]  p;
    logic [W-1:0]  one_val;               // 1 mod p
    logic          advance;

    logic          mul_start;
    logic [W-1:0]  mul_x;
    logic [W-1:0]  mul_y;
    logic          mul_busy;
    logic          mul_done;
    logic [W-1:0]  mul_res;

    assign p       = modulus_reg[W-1:0];
    assign one_val = (p == W'(1)) ? '0 : W'(1);

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        mval_next  = mval_reg;
        out_next   = out_reg;
        mul_start  = 1'b0;
        mul_x      = one_val;
        mul_y      = one_val;
        advance    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mval_next = s_masked_value[W-1:0];
                    if (p == '0) begin
                        // no field: result is zero
                        out_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        mul_start  = 1'b1;
                        mul_x      = one_val;
                        mul_y      = s_ephemeral_value[W-1:0];
                        state_next = ST_RED_R;
                    end
                end
            end
            ST_RED_R: begin
                if (mul_done) begin
                    base_next  = mul_res;
                    acc_next   = one_val;
                    exp_next   = exponent_reg[W-1:0];
                    cnt_next   = CW'(W - 1);
                    pass_next  = 1'b0;
                    mul_start  = 1'b1;
                    mul_x      = one_val;
                    mul_y      = one_val;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (mul_done) begin
                    acc_next = mul_res;
                    if (exp_reg[W-1]) begin
                        mul_start  = 1'b1;
                        mul_x      = mul_res;
                        mul_y      = base_reg;
                        state_next = ST_MUL;
                    end else begin
                        advance = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    acc_next = mul_res;
                    advance  = 1'b1;
                end
            end
            ST_RED_M: begin
                if (mul_done) begin
                    base_next  = mul_res;
                    mul_start  = 1'b1;
                    mul_x      = mul_res;
                    mul_y      = acc_reg;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (mul_done) begin
                    out_next   = mul_res;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // end of one exponent bit
        if (advance) begin
            if (cnt_reg == '0) begin
                if (!pass_reg) begin
                    // key done: start the Fermat inverse k^(p-2)
                    base_next  = mul_res;
                    acc_next   = one_val;
                    exp_next   = p - W'(2);
                    cnt_next   = CW'(W - 1);
                    pass_next  = 1'b1;
                    mul_start  = 1'b1;
                    mul_x      = one_val;
                    mul_y      = one_val;
                    state_next = ST_SQ;
                end else begin
                    acc_next   = mul_res;
                    mul_start  = 1'b1;
                    mul_x      = one_val;
                    mul_y      = mval_reg;
                    state_next = ST_RED_M;
                end
            end else begin
                cnt_next   = cnt_reg - CW'(1);
                exp_next   = exp_reg << 1;
                mul_start  = 1'b1;
                mul_x      = mul_res;
                mul_y      = mul_res;
                state_next = ST_SQ;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        cnt_reg  <= cnt_next;
        pass_reg <= pass_next;
        mval_reg <= mval_next;
        out_reg  <= out_next;
    end

    egd_modmul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .p       (p),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_plain_value = DATA_W'(out_reg);

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_IMPLY(a_in_out_excl, aclk, aresetn, m_valid, !s_ready, "ready while result held")
    `ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    `ASSERT_NEXT(a_out_release, aclk, aresetn, m_valid && m_ready, s_ready, "not idle after output")
    `ASSERT_IMPLY(a_mul_launch, aclk, aresetn, mul_start, !mul_busy, "multiplier relaunched while busy")

endmodule

### tb/elgamal_decrypt_mod_p_checker.sv
// Checker for elgamal_decrypt_mod_p: watches the config port and both item channels,
// predicts each plaintext and compares it with the block's output. Depends on egd_pkg.
`timescale 1ns / 1ps

module elgamal_decrypt_mod_p_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [egd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [egd_pkg::DATA_W-1:0]       pwdata,
    input  logic [egd_pkg::DATA_W-1:0]       prdata,
    input  logic                             pready,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [egd_pkg::DATA_W-1:0]       s_ephemeral_value,
    input  logic [egd_pkg::DATA_W-1:0]       s_masked_value,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [egd_pkg::DATA_W-1:0]       m_plain_value,
    output int                               err_count,
    output int                               plain_pending
);
    import egd_pkg::*;

    logic [31:0] field_p;
    logic [31:0] secret_a;
    logic [31:0] expected_plain[$];
    int          errors = 0;

    // base^expo mod m, square-and-multiply from the top bit
    function automatic logic [31:0] field_pow(logic [31:0] base, logic [31:0] expo,
                                              logic [31:0] m);
        logic [63:0] acc;
        int          b;
        acc = 64'd1 % m;
        for (b = 31; b >= 0; b--) begin
            acc = (acc * acc) % m;
            if (expo[b]) begin
                acc = (acc * base) % m;
            end
        end
        return acc[31:0];
    endfunction

    function automatic logic [31:0] decrypt_plain(logic [31:0] p, logic [31:0] a,
                                                  logic [31:0] r, logic [31:0] m);
        logic [31:0] shared_key;
        logic [31:0] key_inv;
        logic [63:0] prod;
        if (p == 32'd0) begin
            return 32'd0;
        end
        shared_key = field_pow(r % p, a, p);
        key_inv    = (p >= 32'd2) ? field_pow(shared_key, p - 32'd2, p) : 32'd0;
        prod       = m % p;
        prod       = (prod * key_inv) % p;
        return prod[31:0];
    endfunction

    always @(posedge aclk) begin : monitor
        logic [31:0] want;
        reg_idx_t    idx;
        if (!aresetn) begin
            field_p  = 32'd3;
            secret_a = 32'd0;
            expected_plain.delete();
        end else begin
            idx = reg_idx_t'(paddr[2]);
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (idx == REG_MODULUS) field_p = pwdata;
                    else                    secret_a = pwdata;
                end else begin
                    want = (idx == REG_MODULUS) ? field_p : secret_a;
                    if (prdata !== want) begin
                        $display("%0t: register %s read: expected %h, actual %h",
                                 $time, idx.name(), want, prdata);
                        errors++;
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (expected_plain.size() == 0) begin
                    $display("%0t: plain_value with no item outstanding: expected none, actual %h",
                             $time, m_plain_value);
                    errors++;
                end else begin
                    want = expected_plain.pop_front();
                    if (m_plain_value !== want) begin
                        $display("%0t: plain_value: expected %h, actual %h",
                                 $time, want, m_plain_value);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = decrypt_plain(field_p, secret_a, s_ephemeral_value, s_masked_value);
                expected_plain = {expected_plain, want};
            end
        end
        err_count     <= errors;
        plain_pending <= expected_plain.size();
    end

endmodule

### tb/elgamal_decrypt_mod_p_tb.sv
// Top of the elgamal_decrypt_mod_p testbench: clock, reset, config writes, ciphertext items
// and result back-pressure. Depends on egd_pkg, the block and elgamal_decrypt_mod_p_checker.
`timescale 1ns / 1ps

module elgamal_decrypt_mod_p_tb;

    import egd_pkg::*;

    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 153;    // plus 19 directed items, about 1850 in all
    localparam int RX_HOLD_CYCLES  = 10000;  // well over one item's worst-case latency
    localparam int SETTLE_CYCLES   = 4500;   // one worst-case item after the queue empties
    localparam int STALL_LIMIT     = 60000;  // hold + worst item + longest gaps, several times

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   s_valid;
    logic                   s_ready;
    logic [DATA_W-1:0]      s_ephemeral_value;
    logic [DATA_W-1:0]      s_masked_value;
    logic                   m_valid;
    logic                   m_ready;
    logic [DATA_W-1:0]      m_plain_value;

    int err_count;
    int plain_pending;
    int idle_cycles;
    bit hold_req;   // asks the result side for one long hold-off
    bit no_idle;    // phase with back-to-back items and no ready gaps

    elgamal_decrypt_mod_p uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ephemeral_value (s_ephemeral_value),
        .s_masked_value    (s_masked_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_plain_value     (m_plain_value)
    );

    elgamal_decrypt_mod_p_checker plain_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ephemeral_value (s_ephemeral_value),
        .s_masked_value    (s_masked_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_plain_value     (m_plain_value),
        .err_count         (err_count),
        .plain_pending     (plain_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Every input known from time zero
    initial begin
        aresetn           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        s_valid           <= 1'b0;
        s_ephemeral_value <= '0;
        s_masked_value    <= '0;
        m_ready           <= 1'b0;
        hold_req          <= 1'b0;
        no_idle           <= 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        if (roll < 98) return $urandom_range(5, 30);
        return $urandom_range(60, 400);
    endfunction

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_access(input reg_idx_t idx, input logic write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering and wait until every item in flight has come out.
    // The extra edge lets the checker's count catch the last accepted item.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (plain_pending != 0) @(posedge aclk);
    endtask

    // New field and key: only with the block idle; read both back afterwards
    task automatic set_field(input logic [31:0] p, input logic [31:0] a);
        drain_results();
        apb_access(REG_MODULUS, 1'b1, p);
        apb_access(REG_PRIV_EXP, 1'b1, a);
        apb_access(REG_MODULUS, 1'b0, '0);
        apb_access(REG_PRIV_EXP, 1'b0, '0);
    endtask

    // Offer one ciphertext item and return at the edge where it is accepted.
    // With no gap, valid simply stays high and only the payload moves on.
    task automatic send_item(input logic [31:0] r, input logic [31:0] m);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_ephemeral_value <= r;
        s_masked_value    <= m;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Result side: random ready gaps, plus the one long hold-off on request.
    // The hold keeps a finished item stuck at the output while the sender keeps offering.
    initial begin : result_side
        bit hold_done;
        int gap;
        hold_done = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 300)) @(posedge aclk);
        end
    end

    // Watchdog: too long with no item and no register access means a hang
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] big_p;
        logic [31:0] p;
        logic [31:0] a;
        logic [31:0] r;
        logic [31:0] m;
        logic [31:0] mod_pick[RAND_PHASES];
        int          ph;
        int          n;
        int          roll;

        big_p    = 32'hFFFF_FFFB;  // largest 32-bit prime
        mod_pick = '{32'hFFFF_FFFB, 32'd65521, 32'h7FFF_FFFF, 32'd7, 32'hFFFF_FFFF, 32'd0,
                     32'd2, 32'd1, 32'd3, 32'd1000003, 32'd0, 32'hFFFF_FFFB};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values read back, then a couple of items under them (p = 3, a = 0)
        apb_access(REG_MODULUS, 1'b0, '0);
        apb_access(REG_PRIV_EXP, 1'b0, '0);
        send_item(32'd5, 32'd7);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Largest prime, all-ones exponent: field extremes and r a multiple of p
        set_field(big_p, 32'hFFFF_FFFF);
        send_item(32'd0, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(big_p, 32'd12345);
        send_item(32'd0, 32'd99);
        send_item(32'd1, big_p - 32'd1);
        send_item(32'd2, 32'd3);
        send_item(big_p - 32'd1, big_p);

        // Zero exponent: key is 1 even when r is a multiple of p
        set_field(big_p, 32'd0);
        send_item(big_p, 32'd77);
        send_item(32'd0, 32'hFFFF_FFFF);

        // Degenerate moduli: zero (no field), one, and two (inverse exponent zero)
        set_field(32'd0, 32'd5);
        send_item(32'd123, 32'd456);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_field(32'd1, 32'hFFFF_FFFF);
        send_item(32'd7, 32'd8);
        set_field(32'd2, 32'hFFFF_FFFF);
        send_item(32'd3, 32'd5);
        send_item(32'd2, 32'd7);
        send_item(32'd4, 32'hFFFF_FFFF);

        // Composite modulus: same formula, no primality check
        set_field(32'd15, 32'd3);
        send_item(32'd2, 32'd7);
        send_item(32'd5, 32'd9);

        // Random phases over a spread of moduli and exponents
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            p = (ph == 10) ? ($urandom | 32'd1) : mod_pick[ph];
            case (ph)
                1:       a = 32'hFFFF_FFFF;
                3:       a = 32'd0;
                8:       a = 32'd1;
                6:       a = $urandom_range(0, 15);
                default: a = $urandom;
            endcase
            set_field(p, a);
            no_idle <= (ph == 0) || (ph % 5 == 4);
            // First phase: sender runs flat out while the result side holds off
            if (ph == 0) hold_req <= 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    r = (p == 32'd0) ? 32'd0 : p * $urandom_range(0, 32'hFFFF_FFFF / p);
                end else if (roll < 16) begin
                    r = $urandom_range(0, 3);
                end else if (roll < 22) begin
                    r = p - $urandom_range(1, 2);
                end else if (roll < 26) begin
                    r = 32'hFFFF_FFFF - $urandom_range(0, 3);
                end else begin
                    r = $urandom;
                end
                roll = $urandom_range(0, 99);
                if (roll < 5)       m = 32'd0;
                else if (roll < 10) m = 32'hFFFF_FFFF;
                else if (roll < 15) m = p - 32'd1;
                else                m = $urandom;
                send_item(r, m);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0 && plain_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/egd_pkg.sv
rtl/egd_modmul.sv
rtl/elgamal_decrypt_mod_p.sv
tb/elgamal_decrypt_mod_p_checker.sv
tb/elgamal_decrypt_mod_p_tb.sv
